// ===== design/pssb_pkg.sv =====
// Package: shared types, constants and coefficient tables of the SSB demodulator.
`default_nettype none
package pssb_pkg;
	localparam int SAMPLE_W = 24;
	localparam int SB_W     = 26;
	localparam int LP_W     = 27;
	localparam int GAIN_W   = 16;
	localparam int RATIO_W  = 5;
	localparam int CODE_W   = 12;
	localparam int ACC_W    = 56;

	// Filter lengths follow the coefficient tables below.
	localparam int HILBERT_TAPS = 31;
	localparam int LOWPASS_TAPS = 51;
	localparam int HIL_IW       = $clog2(HILBERT_TAPS);
	localparam int LP_IW        = $clog2(LOWPASS_TAPS);
	// Cycles from the last tap until its product sits in the accumulator.
	localparam int MAC_DRAIN    = 2;

	// Register indexes of the configuration port.
	localparam logic [1:0] REG_SIDEBAND = 2'd0;
	localparam logic [1:0] REG_GAIN     = 2'd1;
	localparam logic [1:0] REG_RATIO    = 2'd2;

	// Command from controller to datapath.
	typedef struct packed {
		logic load;      // push new sample pair into the histories
		logic clr_acc;   // clear accumulator
		logic mac_hil;   // accumulate one Hilbert tap
		logic fin_hil;   // form sideband sum and push it
		logic mac_lp;    // accumulate one lowpass tap
		logic fin_lp;    // register lowpass output
		logic scale;     // multiply by gain and clip
		logic [6:0] tap;
	} pssb_cmd_t;

	// Hilbert coefficients, Q1.17.
	function automatic logic signed [17:0] hil_coef(input logic [5:0] k);
		logic signed [17:0] c;
		c = '0;
		unique case (k)
			6'd0: c = 18'sd550;     6'd2: c = 18'sd1217;   6'd4: c = 18'sd2469;
			6'd6: c = 18'sd4509;    6'd8: c = 18'sd7806;   6'd10: c = 18'sd13505;
			6'd12: c = 18'sd25799;  6'd14: c = 18'sd82753;
			6'd16: c = -18'sd82753; 6'd18: c = -18'sd25799; 6'd20: c = -18'sd13505;
			6'd22: c = -18'sd7806;  6'd24: c = -18'sd4509;  6'd26: c = -18'sd2469;
			6'd28: c = -18'sd1217;  6'd30: c = -18'sd550;
			default: c = '0;
		endcase
		return c;
	endfunction

	// Lowpass coefficients, Q1.17, symmetric about tap 25.
	function automatic logic signed [17:0] lp_coef(input logic [6:0] k);
		logic signed [17:0] c;
		logic [6:0] m;
		m = (k > 7'd25) ? 7'd50 - k : k;
		c = '0;
		unique case (m)
			7'd0: c = -18'sd1047;  7'd1: c = -18'sd4233;  7'd2: c = -18'sd335;
			7'd3: c = -18'sd984;   7'd4: c = -18'sd204;   7'd5: c = 18'sd430;
			7'd6: c = 18'sd1153;   7'd7: c = 18'sd1719;   7'd8: c = 18'sd1996;
			7'd9: c = 18'sd1869;   7'd10: c = 18'sd1290;  7'd11: c = 18'sd301;
			7'd12: c = -18'sd956;  7'd13: c = -18'sd2251; 7'd14: c = -18'sd3316;
			7'd15: c = -18'sd3853; 7'd16: c = -18'sd3621; 7'd17: c = -18'sd2455;
			7'd18: c = -18'sd335;  7'd19: c = 18'sd2635;  7'd20: c = 18'sd6197;
			7'd21: c = 18'sd9973;  7'd22: c = 18'sd13548; 7'd23: c = 18'sd16477;
			7'd24: c = 18'sd18399; 7'd25: c = 18'sd19071;
			default: c = '0;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

// ===== design/pssb_datapath.sv =====
// Datapath: sample histories, one shared multiply-accumulate unit and output scaling.
`default_nettype none
module pssb_datapath #(
	parameter int INPHASE_DELAY = 15
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire pssb_pkg::pssb_cmd_t cmd,
	input  wire logic signed [pssb_pkg::SAMPLE_W-1:0] sample_i,
	input  wire logic signed [pssb_pkg::SAMPLE_W-1:0] sample_q,
	input  wire logic lower_sideband,
	input  wire logic [pssb_pkg::GAIN_W-1:0] output_gain,
	output logic [pssb_pkg::CODE_W-1:0] dac_code,
	output logic clipped
);
	logic signed [pssb_pkg::SAMPLE_W-1:0] ih_q [INPHASE_DELAY+1];
	logic signed [pssb_pkg::SAMPLE_W-1:0] qh_q [pssb_pkg::HILBERT_TAPS];
	logic signed [pssb_pkg::SB_W-1:0]     sb_mem [pssb_pkg::LOWPASS_TAPS];
	logic [pssb_pkg::LP_IW-1:0]           head_q;
	logic [pssb_pkg::LP_IW-1:0]           head_nxt;
	logic [pssb_pkg::LP_IW-1:0]           fill_q;
	logic [6:0]                           rd_diff;
	logic [pssb_pkg::LP_IW-1:0]           rd_addr;
	logic signed [pssb_pkg::SB_W-1:0]     sb_rd_s1;
	logic signed [pssb_pkg::SAMPLE_W-1:0] hq_rd_s1;
	logic signed [17:0]                   coef_s1;
	logic                                 sel_lp_s1;
	logic                                 live_s1;
	logic                                 mac_v_s1;
	logic signed [pssb_pkg::ACC_W-1:0]    acc_q;
	logic signed [pssb_pkg::SB_W-1:0]     opnd;
	logic signed [17:0]                   coef;
	logic signed [43:0]                   prod_s2;
	logic                                 prod_v_s2;
	logic signed [pssb_pkg::LP_W-1:0]     lp_q;
	logic signed [pssb_pkg::ACC_W-1:0]    acc_sh;
	logic signed [pssb_pkg::ACC_W-1:0]    sb_wide;
	logic signed [pssb_pkg::SB_W-1:0]     sb_sat;
	logic signed [43:0]                   scaled_full;
	logic signed [27:0]                   scaled;
	logic signed [28:0]                   code_w;

	// Coefficient of the current tap and the lowpass history slot that holds its sample.
	always_comb begin
		if (cmd.mac_hil)
			coef = pssb_pkg::hil_coef(cmd.tap[5:0]);
		else
			coef = pssb_pkg::lp_coef(cmd.tap);
		head_nxt = (head_q == pssb_pkg::LP_IW'(pssb_pkg::LOWPASS_TAPS - 1)) ?
			'0 : head_q + pssb_pkg::LP_IW'(1);
		rd_diff = 7'(head_q) - cmd.tap;
		if (rd_diff[6])
			rd_addr = pssb_pkg::LP_IW'(rd_diff + 7'(pssb_pkg::LOWPASS_TAPS));
		else
			rd_addr = rd_diff[pssb_pkg::LP_IW-1:0];
	end

	// Multiplier operand; lowpass slots not yet written since reset read as zero.
	always_comb begin
		if (!sel_lp_s1)
			opnd = pssb_pkg::SB_W'(hq_rd_s1);
		else if (live_s1)
			opnd = sb_rd_s1;
		else
			opnd = '0;
	end

	// Floor of the accumulator by 2^17, then sideband sum with saturation.
	always_comb begin
		acc_sh = acc_q >>> 17;
		if (lower_sideband)
			sb_wide = pssb_pkg::ACC_W'(ih_q[INPHASE_DELAY]) + acc_sh;
		else
			sb_wide = pssb_pkg::ACC_W'(ih_q[INPHASE_DELAY]) - acc_sh;
		if (sb_wide > pssb_pkg::ACC_W'(33554431))
			sb_sat = 26'sd33554431;
		else if (sb_wide < -pssb_pkg::ACC_W'(33554432))
			sb_sat = -26'sd33554432;
		else
			sb_sat = sb_wide[pssb_pkg::SB_W-1:0];
	end

	// Gain scaling and offset; clipping happens in the output register.
	always_comb begin
		scaled_full = lp_q * $signed({1'b0, output_gain});
		scaled      = scaled_full[43:16];
		code_w      = 29'(scaled) + 29'sd2048;
	end

	// Lowpass history memory: one write per sideband sum, one registered read per tap.
	always_ff @(posedge clk) begin
		if (cmd.fin_hil)
			sb_mem[head_nxt] <= sb_sat;
		sb_rd_s1 <= sb_mem[rd_addr];
	end

	// Shift histories, and the newest slot and fill count of the lowpass memory.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= INPHASE_DELAY; k++) ih_q[k] <= '0;
			for (int k = 0; k < pssb_pkg::HILBERT_TAPS; k++) qh_q[k] <= '0;
			head_q <= '0;
			fill_q <= '0;
		end else begin
			if (cmd.load) begin
				ih_q[0] <= sample_i;
				qh_q[0] <= sample_q;
				for (int k = 1; k <= INPHASE_DELAY; k++) ih_q[k] <= ih_q[k-1];
				for (int k = 1; k < pssb_pkg::HILBERT_TAPS; k++) qh_q[k] <= qh_q[k-1];
			end
			if (cmd.fin_hil) begin
				head_q <= head_nxt;
				if (fill_q != pssb_pkg::LP_IW'(pssb_pkg::LOWPASS_TAPS))
					fill_q <= fill_q + pssb_pkg::LP_IW'(1);
			end
		end
	end

	// Operand register and multiply stage.
	always_ff @(posedge clk) begin
		if (cmd.mac_hil)
			hq_rd_s1 <= qh_q[cmd.tap[pssb_pkg::HIL_IW-1:0]];
		coef_s1   <= coef;
		sel_lp_s1 <= cmd.mac_lp;
		live_s1   <= (cmd.tap < 7'(fill_q));
		prod_s2   <= opnd * coef_s1;
	end

	// Pipeline valid bits, accumulator and output registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mac_v_s1  <= 1'b0;
			prod_v_s2 <= 1'b0;
			acc_q     <= '0;
			lp_q      <= '0;
			dac_code  <= '0;
			clipped   <= 1'b0;
		end else begin
			mac_v_s1  <= cmd.mac_hil | cmd.mac_lp;
			prod_v_s2 <= mac_v_s1;
			if (cmd.clr_acc)
				acc_q <= '0;
			else if (prod_v_s2)
				acc_q <= acc_q + pssb_pkg::ACC_W'(prod_s2);
			if (cmd.fin_lp)
				lp_q <= acc_sh[pssb_pkg::LP_W-1:0];
			if (cmd.scale) begin
				if (code_w < 0) begin
					dac_code <= '0;
					clipped  <= 1'b1;
				end else if (code_w > 29'sd4095) begin
					dac_code <= 12'd4095;
					clipped  <= 1'b1;
				end else begin
					dac_code <= code_w[pssb_pkg::CODE_W-1:0];
					clipped  <= 1'b0;
				end
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/pssb_ctrl.sv =====
// Controller: sequences the multiply-accumulate passes and the stream handshakes.
`default_nettype none
module pssb_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  wire logic out_ready,
	input  wire logic [pssb_pkg::RATIO_W-1:0] decimation_ratio,
	output pssb_pkg::pssb_cmd_t cmd
);
	typedef enum logic [2:0] {
		ST_IDLE, ST_HIL, ST_HDRN, ST_HFIN, ST_LP, ST_LDRN, ST_LFIN, ST_SCALE
	} state_t;

	state_t      state_q;
	logic [6:0]  tap_q;
	logic [3:0]  phase_q;
	logic [4:0]  ratio;
	logic [4:0]  next_ph;
	logic        emit;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		if (decimation_ratio == '0) ratio = 5'd1;
		else if (decimation_ratio > 5'd16) ratio = 5'd16;
		else ratio = decimation_ratio;
		next_ph = 5'(phase_q) + 5'd1;
		emit    = next_ph >= ratio;
	end

	// Commands follow the state and tap counter.
	always_comb begin
		cmd         = '0;
		cmd.tap     = tap_q;
		cmd.load    = in_valid && in_ready;
		cmd.clr_acc = cmd.load || (state_q == ST_HFIN);
		cmd.mac_hil = (state_q == ST_HIL);
		cmd.fin_hil = (state_q == ST_HFIN);
		cmd.mac_lp  = (state_q == ST_LP);
		cmd.fin_lp  = (state_q == ST_LFIN);
		cmd.scale   = (state_q == ST_SCALE) && !out_valid;
	end

	// State, tap counter, decimation phase and result valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			tap_q     <= '0;
			phase_q   <= '0;
			out_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) begin
					state_q <= ST_HIL;
					tap_q   <= '0;
				end
				ST_HIL: begin
					if (tap_q == 7'(pssb_pkg::HILBERT_TAPS - 1)) begin
						state_q <= ST_HDRN;
						tap_q   <= '0;
					end else tap_q <= tap_q + 7'd1;
				end
				// Wait for the last Hilbert product to reach the accumulator.
				ST_HDRN: begin
					if (tap_q == 7'(pssb_pkg::MAC_DRAIN - 1)) state_q <= ST_HFIN;
					else tap_q <= tap_q + 7'd1;
				end
				ST_HFIN: begin
					state_q <= ST_LP;
					tap_q   <= '0;
				end
				ST_LP: begin
					if (tap_q == 7'(pssb_pkg::LOWPASS_TAPS - 1)) begin
						state_q <= ST_LDRN;
						tap_q   <= '0;
					end else tap_q <= tap_q + 7'd1;
				end
				// Wait for the last lowpass product to reach the accumulator.
				ST_LDRN: begin
					if (tap_q == 7'(pssb_pkg::MAC_DRAIN - 1)) state_q <= ST_LFIN;
					else tap_q <= tap_q + 7'd1;
				end
				ST_LFIN: begin
					if (emit) begin
						phase_q <= '0;
						state_q <= ST_SCALE;
					end else begin
						phase_q <= next_ph[3:0];
						state_q <= ST_IDLE;
					end
				end
				// The output register is overwritten only once the previous code has left.
				ST_SCALE: begin
					if (!out_valid) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== design/phasing_ssb_demodulator_top.sv =====
// Top level: phasing SSB demodulator with decimated 12-bit DAC output.
`default_nettype none
// One I/Q pair is taken per transaction. Each item runs the Hilbert and lowpass
// filters on one shared, two-stage multiply-accumulate unit, one tap per cycle,
// and after each pass waits for the last product to land; a new pair is taken
// only once the previous item has finished both passes and, on items that emit
// a code, the scaling step. A new pair may be taken while a code waits at the
// output; the scaling step of the next emitting item then waits until that code
// has left. A DAC code is emitted every decimation_ratio items (0 acts as 1,
// above 16 as 16). The lowpass history is a memory with a fill count, so slots
// not written since reset read as zero.
module phasing_ssb_demodulator_top #(
	parameter int INPHASE_DELAY = 15
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input  wire logic [47:0] s_axis_tdata, // sample_i [23:0], sample_q [47:24]
	output logic m_axis_tvalid,
	input  wire logic m_axis_tready,
	output logic [15:0] m_axis_tdata, // dac_code [11:0], clipped [12], zero [15:13]
	input  wire logic cfg_we,
	input  wire logic [1:0] cfg_index,
	input  wire logic [15:0] cfg_data
);
	pssb_pkg::pssb_cmd_t cmd;
	logic sideband_q;
	logic [pssb_pkg::GAIN_W-1:0] gain_q;
	logic [pssb_pkg::RATIO_W-1:0] ratio_q;
	logic [pssb_pkg::CODE_W-1:0] dac_code;
	logic clipped;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sideband_q <= 1'b1;
			gain_q     <= 16'd655;
			ratio_q    <= 5'd6;
		end else if (cfg_we) begin
			if (cfg_index == pssb_pkg::REG_SIDEBAND) sideband_q <= cfg_data[0];
			if (cfg_index == pssb_pkg::REG_GAIN) gain_q <= cfg_data;
			if (cfg_index == pssb_pkg::REG_RATIO) ratio_q <= cfg_data[4:0];
		end
	end

	pssb_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.decimation_ratio(ratio_q), .cmd(cmd)
	);

	pssb_datapath #(
		.INPHASE_DELAY(INPHASE_DELAY)
	) u_dp (
		.clk, .arst_n, .cmd(cmd),
		.sample_i(s_axis_tdata[23:0]), .sample_q(s_axis_tdata[47:24]),
		.lower_sideband(sideband_q), .output_gain(gain_q),
		.dac_code(dac_code), .clipped(clipped)
	);

	assign m_axis_tdata = {3'b000, clipped, dac_code};

	// A clipped code sits at one of the two rails.
	a_clip_rail: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tdata[12] |->
		(m_axis_tdata[11:0] == 12'd0 || m_axis_tdata[11:0] == 12'd4095))
		else $error("clip flag without rail code");
	// A waiting result stays valid and unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while waiting");
	// Only one MAC pass at a time.
	a_one_pass: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.mac_hil && cmd.mac_lp))
		else $error("overlapping filter passes");
endmodule
`default_nettype wire

// ===== verif/tb_top.sv =====
// Testbench of the phasing SSB demodulator: directed table, random phases, predictor check.
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	localparam int HIL_N = 31;
	localparam int LP_N = 51;
	localparam int I_DELAY = 15;
	localparam int SETTLE_CYCLES = 120;
	localparam int CYCLE_LIMIT = 1000000;
	localparam logic [1:0] REG_UNUSED = 2'd3;

	// Filter taps in Q1.17.
	localparam int HIL_TAPS [HIL_N] = '{
		550, 0, 1217, 0, 2469, 0, 4509, 0, 7806, 0, 13505, 0, 25799, 0, 82753, 0,
		-82753, 0, -25799, 0, -13505, 0, -7806, 0, -4509, 0, -2469, 0, -1217, 0, -550};
	localparam int LP_TAPS [LP_N] = '{
		-1047, -4233, -335, -984, -204, 430, 1153, 1719, 1996, 1869, 1290, 301,
		-956, -2251, -3316, -3853, -3621, -2455, -335, 2635, 6197, 9973, 13548,
		16477, 18399, 19071, 18399, 16477, 13548, 9973, 6197, 2635, -335, -2455,
		-3621, -3853, -3316, -2251, -956, 301, 1290, 1869, 1996, 1719, 1153, 430,
		-204, -984, -335, -4233, -1047};

	typedef struct {
		logic [11:0] code;
		logic clip;
	} dac_word_t;

	typedef struct {
		int si;
		int sq;
		bit typed;
		logic [11:0] code;
		logic clip;
	} pair_row_t;

	// Directed pairs at the reset configuration (ratio 6, gain 655, lower sideband).
	localparam int N_ROWS = 18;
	pair_row_t pair_rows [N_ROWS] = '{
		'{0, 0, 0, 12'd0, 1'b0}, '{0, 0, 0, 12'd0, 1'b0}, '{0, 0, 0, 12'd0, 1'b0},
		'{0, 0, 0, 12'd0, 1'b0}, '{0, 0, 0, 12'd0, 1'b0}, '{0, 0, 1, 12'd2048, 1'b0},
		'{8388607, 8388607, 0, 12'd0, 1'b0}, '{-8388608, -8388608, 0, 12'd0, 1'b0},
		'{8388607, -8388608, 0, 12'd0, 1'b0}, '{-8388608, 8388607, 0, 12'd0, 1'b0},
		'{1, -1, 0, 12'd0, 1'b0}, '{-1, 1, 0, 12'd0, 1'b0},
		'{5592405, -5592406, 0, 12'd0, 1'b0}, '{-5592406, 5592405, 0, 12'd0, 1'b0},
		'{8388607, 8388607, 0, 12'd0, 1'b0}, '{8388607, 8388607, 0, 12'd0, 1'b0},
		'{0, 0, 0, 12'd0, 1'b0}, '{-8388608, -8388608, 0, 12'd0, 1'b0}};

	logic clk;
	logic arst_n;
	logic s_axis_tvalid;
	logic s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic m_axis_tvalid;
	logic m_axis_tready;
	logic [15:0] m_axis_tdata;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [15:0] cfg_data;

	// Predictor state and configuration.
	bit mdl_lower;
	int mdl_gain;
	int mdl_ratio;
	longint i_hist [I_DELAY + 1];
	longint q_hist [HIL_N];
	longint sb_hist [LP_N];
	int dec_phase;

	dac_word_t dac_pending [$];
	int n_fail;
	int n_sent;
	int n_codes;
	int tx_idle_pct;
	int rx_idle_pct;
	int cycles;
	bit typed_next;
	dac_word_t typed_word;

	phasing_ssb_demodulator_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), // sample_i [23:0], sample_q [47:24]
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), // dac_code [11:0], clipped [12]
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Clear the predictor to its reset state.
	function automatic void demod_reset();
		mdl_lower = 1'b1;
		mdl_gain = 655;
		mdl_ratio = 6;
		foreach (i_hist[k]) i_hist[k] = 0;
		foreach (q_hist[k]) q_hist[k] = 0;
		foreach (sb_hist[k]) sb_hist[k] = 0;
		dec_phase = 0;
	endfunction

	// Advance the filters by one pair; returns 1 when a DAC code falls due.
	function automatic bit demod_step(input logic [23:0] si, input logic [23:0] sq,
			output dac_word_t w);
		longint acc;
		longint hq;
		longint sb;
		longint lp;
		longint code;
		int ratio;
		for (int k = I_DELAY; k > 0; k--) i_hist[k] = i_hist[k - 1];
		i_hist[0] = longint'($signed(si));
		for (int k = HIL_N - 1; k > 0; k--) q_hist[k] = q_hist[k - 1];
		q_hist[0] = longint'($signed(sq));
		acc = 0;
		for (int k = 0; k < HIL_N; k++) acc += q_hist[k] * HIL_TAPS[k];
		hq = acc >>> 17;
		sb = mdl_lower ? i_hist[I_DELAY] + hq : i_hist[I_DELAY] - hq;
		if (sb > 33554431) sb = 33554431;
		if (sb < -33554432) sb = -33554432;
		for (int k = LP_N - 1; k > 0; k--) sb_hist[k] = sb_hist[k - 1];
		sb_hist[0] = sb;
		acc = 0;
		for (int k = 0; k < LP_N; k++) acc += sb_hist[k] * LP_TAPS[k];
		lp = acc >>> 17;
		ratio = (mdl_ratio == 0) ? 1 : (mdl_ratio > 16 ? 16 : mdl_ratio);
		w.code = '0;
		w.clip = 1'b0;
		if (dec_phase + 1 < ratio) begin
			dec_phase = (dec_phase + 1) & 15;
			return 1'b0;
		end
		dec_phase = 0;
		code = ((lp * mdl_gain) >>> 16) + 2048;
		if (code < 0) begin
			code = 0;
			w.clip = 1'b1;
		end else if (code > 4095) begin
			code = 4095;
			w.clip = 1'b1;
		end
		w.code = code[11:0];
		return 1'b1;
	endfunction

	// Input and output transactions: check results, then predict for a new pair.
	always @(posedge clk) begin
		dac_word_t w;
		dac_word_t got;
		if (m_axis_tvalid && m_axis_tready) begin
			got.code = m_axis_tdata[11:0];
			got.clip = m_axis_tdata[12];
			n_codes++;
			if (dac_pending.size() == 0) begin
				$error("unexpected DAC code %0d", got.code);
				n_fail++;
			end else begin
				w = dac_pending.pop_front();
				if (got.code !== w.code) begin
					$error("dac_code: expected %0d, got %0d", w.code, got.code);
					n_fail++;
				end
				if (got.clip !== w.clip) begin
					$error("clipped: expected %0b, got %0b", w.clip, got.clip);
					n_fail++;
				end
			end
		end
		if (s_axis_tvalid && s_axis_tready) begin
			if (demod_step(s_axis_tdata[23:0], s_axis_tdata[47:24], w))
				dac_pending.push_back(typed_next ? typed_word : w);
		end
	end

	// Cycle counter and watchdog.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Receiver: random back-pressure, and one long hold-off that fills the block.
	initial begin
		bit held;
		held = 1'b0;
		m_axis_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && n_codes >= 40) begin
				held = 1'b1;
				m_axis_tready <= 1'b0;
				repeat (400) @(posedge clk);
			end
			m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// Offer one pair and wait for its transaction.
	task automatic send_pair(input logic [23:0] si, input logic [23:0] sq);
		if (n_sent < 250) begin
			tx_idle_pct = 6;
			rx_idle_pct = 83;
		end else if (n_sent < 500) begin
			tx_idle_pct = 83;
			rx_idle_pct = 6;
		end else begin
			tx_idle_pct = 0;
			rx_idle_pct = 0;
		end
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {sq, si};
		do @(posedge clk); while (!s_axis_tready);
		n_sent++;
	endtask

	// Wait until every due code has arrived and the block has finished its pair.
	task automatic wait_idle();
		s_axis_tvalid <= 1'b0;
		while (dac_pending.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (idx)
			pssb_pkg::REG_SIDEBAND: mdl_lower = val[0];
			pssb_pkg::REG_GAIN: mdl_gain = val;
			pssb_pkg::REG_RATIO: mdl_ratio = val[4:0];
			default: ;
		endcase
	endtask

	// Mix of full-scale, extreme, small and zero samples.
	function automatic logic [23:0] rand_sample();
		case ($urandom_range(3))
			0: return 24'($urandom);
			1: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
			2: return 24'($signed($urandom_range(8192)) - 4096);
			default: return 24'(0);
		endcase
	endfunction

	task automatic run_phase(input bit lower, input int gain, input int ratio, input int n);
		wait_idle();
		write_reg(pssb_pkg::REG_SIDEBAND, 16'(lower));
		write_reg(pssb_pkg::REG_GAIN, 16'(gain));
		write_reg(pssb_pkg::REG_RATIO, 16'(ratio));
		for (int k = 0; k < n; k++) send_pair(rand_sample(), rand_sample());
	endtask

	initial begin
		n_fail = 0;
		n_sent = 0;
		n_codes = 0;
		cycles = 0;
		tx_idle_pct = 6;
		rx_idle_pct = 83;
		typed_next = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = pssb_pkg::REG_SIDEBAND;
		cfg_data = '0;
		demod_reset();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table at the reset configuration; the expected word travels with its pair.
		foreach (pair_rows[r]) begin
			typed_next <= pair_rows[r].typed;
			typed_word.code <= pair_rows[r].code;
			typed_word.clip <= pair_rows[r].clip;
			send_pair(24'(pair_rows[r].si), 24'(pair_rows[r].sq));
		end
		@(posedge clk);
		typed_next <= 1'b0;

		// Random phases: extremes of gain and ratio, ratio zero and out of range.
		run_phase(1'b0, 65535, 1, 60);
		run_phase(1'b1, 0, 0, 30);
		run_phase(1'b0, 1000, 31, 100);
		// Ratio lowered while the decimation count is part way through.
		run_phase(1'b1, 40000, 16, 5);
		run_phase(1'b1, 40000, 2, 60);
		// A write to an unknown index changes no register; the next phase rewrites all three.
		wait_idle();
		write_reg(REG_UNUSED, 16'($urandom));
		run_phase(1'b1, 655, 6, 200);
		run_phase(1'b0, 20000, 17, 100);
		run_phase(1'b1, 65535, 3, 150);
		wait_idle();

		if (n_fail == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ===== phasing_ssb_demodulator_top.f =====
design/pssb_pkg.sv
design/pssb_datapath.sv
design/pssb_ctrl.sv
design/phasing_ssb_demodulator_top.sv
verif/tb_top.sv
